// ----- hdl/gls_pkg.sv -----
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types and constants of the fixed-point Gaussian elimination solver.
// ----------------------------------------------------------------------------
package gls_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;

    localparam logic [3:0] ORDER_RESET = 4'd8;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SINGULAR  = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_COPY,
        OP_PIV,
        OP_FACT,
        OP_ELIM,
        OP_NORM,
        OP_BINIT,
        OP_BSUB,
        OP_BSTORE,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY,
        ST_PIV,
        ST_FACT,
        ST_ELIM,
        ST_NORM,
        ST_BINIT,
        ST_BSUB,
        ST_BSTORE,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_READ,
        DP_MUL,
        DP_DIV
    } dp_state_t;

    typedef struct packed {
        logic load;    // store the accepted load transaction
        logic clr;     // clear solve status
        logic start;   // begin operation op
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;      // operation finished this cycle
        logic piv_zero;  // with done of OP_PIV: pivot is zero
    } sts_t;

endpackage

// ----- hdl/gaussian_linear_solver_core.sv -----
// ----------------------------------------------------------------------------
// gaussian_linear_solver_core
// Solves A x = b in signed fixed point by Gaussian elimination with
// unit-diagonal row normalization and back substitution.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one matrix or right-hand side element
//    per transaction. in_ready is high whenever no solve is running, so loads
//    go at one per cycle. A transaction with start_solve stores its element
//    and then starts a solve on a working copy; the loaded data stays.
//  - cfg_write_en/cfg_write_data set the order n (0 acts as 1, values above
//    MAX_ORDER act as MAX_ORDER); write it only while idle.
//  - Output channel (out_valid/out_ready): x[0] .. x[n-1], last one marked,
//    each carrying the solve status (ok, singular, saturated).
//  - Solve steps: a copy sweep over all MAX_ORDER*(MAX_ORDER+1) store entries,
//    then per elimination step i row updates plus divisions in the bit-serial
//    divider, then back substitution term by term. Every operation goes
//    through the single work-matrix memory port pair.
//  - A stalled receiver holds the result register; the sequencer waits and
//    resumes once it is taken. Reset clears control and status only; the
//    stores are undefined until loaded.
// ----------------------------------------------------------------------------
module gaussian_linear_solver_core
    import gls_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic [3:0]               cfg_write_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               row_index,
    input  logic [2:0]               column_index,
    input  logic                     is_rhs,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic                     start_solve,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               unknown_index,
    output logic signed [DATA_W-1:0] solution_value,
    output logic                     last_unknown,
    output logic [1:0]               solve_status
);

    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam int AW = $clog2(MAX_ORDER * (MAX_ORDER + 1));

    cmd_t          cmd;
    sts_t          sts;
    logic [CW-1:0] idx_i, idx_r, idx_k, n_eff;
    logic [AW-1:0] cpy_addr;

    gls_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .CW        (CW),
        .AW        (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .start_solve    (start_solve),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .sts            (sts),
        .idx_i          (idx_i),
        .idx_r          (idx_r),
        .idx_k          (idx_k),
        .cpy_addr       (cpy_addr),
        .n_eff          (n_eff)
    );

    gls_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .AW        (AW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .idx_i          (idx_i),
        .idx_r          (idx_r),
        .idx_k          (idx_k),
        .cpy_addr       (cpy_addr),
        .n_eff          (n_eff),
        .row_index      (row_index),
        .column_index   (column_index),
        .is_rhs         (is_rhs),
        .element_value  (element_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .unknown_index  (unknown_index),
        .solution_value (solution_value),
        .last_unknown   (last_unknown),
        .solve_status   (solve_status)
    );

    // no operation is issued while loads are being taken
    a_idle_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.start)
        else $error("operation issued while idle");

    // one operation in flight: a start is never followed directly by another
    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !cmd.start)
        else $error("back-to-back operation starts");

    // completion never coincides with issuing a new operation
    a_done_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> !cmd.start)
        else $error("operation done while a new one starts");

endmodule

// ----- hdl/gls_div.sv -----
// ----------------------------------------------------------------------------
// gls_div
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module gls_div
    import gls_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W-1:0] den,
    output logic                     done,
    output logic signed [DATA_W-1:0] quot,
    output logic                     ovf
);

    localparam int NW  = DATA_W + FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]     sh_reg, sh_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dmag_reg, dmag_next;
    logic [CNW-1:0]    cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;
    logic [DATA_W-1:0] nmag;
    logic              q_pos_ovf, q_neg_ovf;

    always_comb
    begin
        nmag      = num[DATA_W-1] ? (~num + 1'b1) : num;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, sh_reg[NW-1]};
        rem_sub   = rem_sh - {1'b0, dmag_reg};
        if (start)
        begin
            sh_next   = {nmag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dmag_next = den[DATA_W-1] ? (~den + 1'b1) : den;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            cnt_next  = CNW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            if (!rem_sub[DATA_W])
            begin
                rem_next = rem_sub[DATA_W-1:0];
                sh_next  = {sh_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                sh_next  = {sh_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    // sh_reg holds the quotient magnitude once done
    assign q_pos_ovf = (sh_reg[NW-1:DATA_W-1] != '0);
    assign q_neg_ovf = (sh_reg[NW-1:DATA_W] != '0)
                    || (sh_reg[DATA_W-1] && (sh_reg[DATA_W-2:0] != '0));

    always_comb
    begin
        if (neg_reg)
        begin
            ovf  = q_neg_ovf;
            quot = q_neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}}
                             : -$signed(sh_reg[DATA_W-1:0]);
        end
        else
        begin
            ovf  = q_pos_ovf;
            quot = q_pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}}
                             : $signed(sh_reg[DATA_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

// ----- hdl/gls_datapath.sv -----
// ----------------------------------------------------------------------------
// gls_datapath
// Load store, working matrix, factor and solution arrays, multiplier,
// divider and the output register. Executes one controller operation at a time.
// ----------------------------------------------------------------------------
module gls_datapath
    import gls_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CW        = $clog2(MAX_ORDER + 1),
    parameter int AW        = $clog2(MAX_ORDER * (MAX_ORDER + 1))
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [CW-1:0]            idx_i,
    input  logic [CW-1:0]            idx_r,
    input  logic [CW-1:0]            idx_k,
    input  logic [AW-1:0]            cpy_addr,
    input  logic [CW-1:0]            n_eff,
    input  logic [2:0]               row_index,
    input  logic [2:0]               column_index,
    input  logic                     is_rhs,
    input  logic signed [DATA_W-1:0] element_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               unknown_index,
    output logic signed [DATA_W-1:0] solution_value,
    output logic                     last_unknown,
    output logic [1:0]               solve_status
);

    localparam int COLS  = MAX_ORDER + 1;
    localparam int DEPTH = MAX_ORDER * COLS;
    localparam int RW    = $clog2(MAX_ORDER);
    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic [AW-1:0] loc(input logic [CW-1:0] row,
                                          input logic [CW-1:0] col);
        loc = AW'(int'(row) * COLS + int'(col));
    endfunction

    // {overflow, saturated a - b}
    function automatic logic [DATA_W:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                               input logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1])
            sub_sat = {1'b1, d[DATA_W] ? SMIN : SMAX};
        else
            sub_sat = {1'b0, d[DATA_W-1:0]};
    endfunction

    logic signed [DATA_W-1:0] aug_mem  [DEPTH];
    logic signed [DATA_W-1:0] work_mem [DEPTH];
    logic signed [DATA_W-1:0] fac_mem  [MAX_ORDER];
    logic signed [DATA_W-1:0] sol_mem  [MAX_ORDER];

    logic signed [DATA_W-1:0] aug_rd_reg, rd0_reg, rd1_reg, fac_rd_reg, sol_rd_reg;

    dp_state_t                dps_reg, dps_next;
    logic signed [DATA_W-1:0] piv_reg, piv_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic                     sat_reg, sat_next;
    logic                     sing_reg, sing_next;
    logic                     ovalid_reg, ovalid_next;
    logic [2:0]               oidx_reg, oidx_next;
    logic signed [DATA_W-1:0] oval_reg, oval_next;
    logic                     olast_reg, olast_next;
    logic [1:0]               ostat_reg, ostat_next;

    logic [AW-1:0]            ra0, ra1, wa, ld_addr;
    logic                     we, ld_we;
    logic signed [DATA_W-1:0] wd;
    logic [RW-1:0]            sol_ra;
    logic                     fac_we, sol_we;
    logic signed [DATA_W-1:0] fac_wd;

    logic                     div_start, div_done, div_ovf;
    logic signed [DATA_W-1:0] div_q;

    logic signed [63:0]       shp;
    logic                     shp_ovf;
    logic signed [DATA_W-1:0] prod_t;
    logic [DATA_W:0]          diff;
    logic                     last_w;

    gls_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rd0_reg),
        .den   (piv_reg),
        .done  (div_done),
        .quot  (div_q),
        .ovf   (div_ovf)
    );

    // Read addresses follow the operation the controller holds
    always_comb
    begin
        ra0    = loc(idx_i, idx_i);
        ra1    = loc(idx_r, idx_k);
        sol_ra = idx_k[RW-1:0];
        case (cmd.op)
            OP_PIV:   ra0 = loc(idx_i, idx_i);
            OP_FACT:  ra0 = loc(idx_r, idx_i);
            OP_ELIM:  ra0 = loc(idx_i, idx_k);
            OP_NORM:  ra0 = loc(idx_i, idx_k);
            OP_BINIT: ra0 = loc(idx_i, CW'(MAX_ORDER));
            OP_BSUB:  ra0 = loc(idx_i, idx_k);
            OP_EMIT:  sol_ra = idx_r[RW-1:0];
            default:  ra0 = loc(idx_i, idx_i);
        endcase
        ld_addr = AW'(int'(row_index) * COLS
                      + (is_rhs ? MAX_ORDER : int'(column_index)));
        ld_we   = cmd.load && (int'(row_index) < MAX_ORDER)
               && (is_rhs || (int'(column_index) < MAX_ORDER));
    end

    always_comb
    begin
        shp     = prod_reg >>> FRAC_BITS;
        shp_ovf = !((&shp[63:DATA_W-1]) || (~|shp[63:DATA_W-1]));
        prod_t  = shp_ovf ? (shp[63] ? SMIN : SMAX) : shp[DATA_W-1:0];
        diff    = sub_sat((cmd.op == OP_ELIM) ? rd1_reg : acc_reg, prod_t);
        last_w  = (({1'b0, idx_r} + (CW+1)'(1)) == {1'b0, n_eff});
    end

    always_comb
    begin
        dps_next    = dps_reg;
        piv_next    = piv_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        sat_next    = sat_reg;
        sing_next   = sing_reg;
        ovalid_next = ovalid_reg && !out_ready;
        oidx_next   = oidx_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        ostat_next  = ostat_reg;
        we          = 1'b0;
        wa          = cpy_addr;
        wd          = aug_rd_reg;
        fac_we      = 1'b0;
        fac_wd      = div_q;
        sol_we      = 1'b0;
        div_start   = 1'b0;
        sts         = '0;
        if (cmd.clr)
        begin
            sat_next  = 1'b0;
            sing_next = 1'b0;
        end
        case (dps_reg)
            DP_IDLE:
            begin
                if (cmd.start)
                    dps_next = DP_READ;
            end
            DP_READ:
            begin
                case (cmd.op)
                    OP_COPY:
                    begin
                        we       = 1'b1;
                        sts.done = 1'b1;
                        dps_next = DP_IDLE;
                    end
                    OP_PIV:
                    begin
                        piv_next     = rd0_reg;
                        sts.done     = 1'b1;
                        sts.piv_zero = (rd0_reg == '0);
                        if (rd0_reg == '0)
                            sing_next = 1'b1;
                        dps_next = DP_IDLE;
                    end
                    OP_FACT, OP_NORM:
                    begin
                        div_start = 1'b1;
                        dps_next  = DP_DIV;
                    end
                    OP_ELIM:
                    begin
                        prod_next = 64'(rd0_reg) * 64'(fac_rd_reg);
                        dps_next  = DP_MUL;
                    end
                    OP_BSUB:
                    begin
                        prod_next = 64'(rd0_reg) * 64'(sol_rd_reg);
                        dps_next  = DP_MUL;
                    end
                    OP_BINIT:
                    begin
                        acc_next = rd0_reg;
                        sts.done = 1'b1;
                        dps_next = DP_IDLE;
                    end
                    OP_BSTORE:
                    begin
                        sol_we   = 1'b1;
                        sts.done = 1'b1;
                        dps_next = DP_IDLE;
                    end
                    OP_EMIT:
                    begin
                        // wait here while the output register is still full
                        if (!ovalid_reg || out_ready)
                        begin
                            ovalid_next = 1'b1;
                            oidx_next   = 3'(idx_r);
                            oval_next   = sing_reg ? '0 : sol_rd_reg;
                            olast_next  = last_w;
                            ostat_next  = sing_reg ? STATUS_SINGULAR
                                        : (sat_reg ? STATUS_SATURATED : STATUS_OK);
                            sts.done    = 1'b1;
                            dps_next    = DP_IDLE;
                        end
                    end
                    default:
                    begin
                        sts.done = 1'b1;
                        dps_next = DP_IDLE;
                    end
                endcase
            end
            DP_MUL:
            begin
                if (shp_ovf || diff[DATA_W])
                    sat_next = 1'b1;
                if (cmd.op == OP_ELIM)
                begin
                    we = 1'b1;
                    wa = loc(idx_r, idx_k);
                    wd = diff[DATA_W-1:0];
                end
                else
                    acc_next = diff[DATA_W-1:0];
                sts.done = 1'b1;
                dps_next = DP_IDLE;
            end
            DP_DIV:
            begin
                if (div_done)
                begin
                    if (div_ovf)
                        sat_next = 1'b1;
                    if (cmd.op == OP_FACT)
                        fac_we = 1'b1;
                    else
                    begin
                        we = 1'b1;
                        wa = loc(idx_i, idx_k);
                        wd = div_q;
                    end
                    sts.done = 1'b1;
                    dps_next = DP_IDLE;
                end
            end
            default: dps_next = DP_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld_we)
            aug_mem[ld_addr] <= element_value;
        aug_rd_reg <= aug_mem[cpy_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we)
            work_mem[wa] <= wd;
        rd0_reg <= work_mem[ra0];
        rd1_reg <= work_mem[ra1];
    end

    always_ff @(posedge clk)
    begin
        if (fac_we)
            fac_mem[idx_r[RW-1:0]] <= fac_wd;
        fac_rd_reg <= fac_mem[idx_r[RW-1:0]];
        if (sol_we)
            sol_mem[idx_i[RW-1:0]] <= acc_reg;
        sol_rd_reg <= sol_mem[sol_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dps_reg    <= DP_IDLE;
            sat_reg    <= 1'b0;
            sing_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            dps_reg    <= dps_next;
            sat_reg    <= sat_next;
            sing_reg   <= sing_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_reg   <= piv_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
        ostat_reg <= ostat_next;
    end

    assign out_valid      = ovalid_reg;
    assign unknown_index  = oidx_reg;
    assign solution_value = oval_reg;
    assign last_unknown   = olast_reg;
    assign solve_status   = ostat_reg;

endmodule

// ----- hdl/gls_ctrl.sv -----
// ----------------------------------------------------------------------------
// gls_ctrl
// Solve sequencer: copy, elimination loops, back substitution and emission.
// Issues one datapath operation at a time and advances on its completion.
// ----------------------------------------------------------------------------
module gls_ctrl
    import gls_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int CW        = $clog2(MAX_ORDER + 1),
    parameter int AW        = $clog2(MAX_ORDER * (MAX_ORDER + 1))
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic [3:0]    cfg_write_data,
    input  logic          in_valid,
    input  logic          start_solve,
    output logic          in_ready,
    output cmd_t          cmd,
    input  sts_t          sts,
    output logic [CW-1:0] idx_i,
    output logic [CW-1:0] idx_r,
    output logic [CW-1:0] idx_k,
    output logic [AW-1:0] cpy_addr,
    output logic [CW-1:0] n_eff
);

    localparam logic [CW-1:0] COL_B     = CW'(MAX_ORDER);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ORDER * (MAX_ORDER + 1) - 1);

    ctrl_state_t   state_reg, state_next;
    logic          pend_reg, pend_next;
    logic [3:0]    order_reg;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] k_reg, k_next;
    logic [AW-1:0] a_reg, a_next;

    // true when c + 1 is still below n
    function automatic logic more(input logic [CW-1:0] c, input logic [CW-1:0] nn);
        more = (({1'b0, c} + (CW+1)'(1)) < {1'b0, nn});
    endfunction

    // column after c: next matrix column, then the right-hand side
    function automatic logic [CW-1:0] next_col(input logic [CW-1:0] c,
                                              input logic [CW-1:0] nn);
        next_col = more(c, nn) ? (c + 1'b1) : COL_B;
    endfunction

    always_comb
    begin
        if (order_reg == '0)
            n_eff = CW'(1);
        else if (int'(order_reg) > MAX_ORDER)
            n_eff = CW'(MAX_ORDER);
        else
            n_eff = CW'(order_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        i_next     = i_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        in_ready   = (state_reg == ST_IDLE);
        cmd        = '0;
        cmd.op     = OP_COPY;
        case (state_reg)
            ST_PIV:    cmd.op = OP_PIV;
            ST_FACT:   cmd.op = OP_FACT;
            ST_ELIM:   cmd.op = OP_ELIM;
            ST_NORM:   cmd.op = OP_NORM;
            ST_BINIT:  cmd.op = OP_BINIT;
            ST_BSUB:   cmd.op = OP_BSUB;
            ST_BSTORE: cmd.op = OP_BSTORE;
            ST_EMIT:   cmd.op = OP_EMIT;
            default:   cmd.op = OP_COPY;
        endcase
        cmd.load = in_valid && in_ready;

        if (state_reg == ST_IDLE)
        begin
            if (in_valid && start_solve)
            begin
                cmd.clr    = 1'b1;
                a_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_COPY;
            end
        end
        else if (!pend_reg)
        begin
            cmd.start = 1'b1;
            pend_next = 1'b1;
        end
        else if (sts.done)
        begin
            pend_next = 1'b0;
            case (state_reg)
                ST_COPY:
                begin
                    if (a_reg == LAST_ADDR)
                    begin
                        i_next     = '0;
                        state_next = ST_PIV;
                    end
                    else
                        a_next = a_reg + 1'b1;
                end
                ST_PIV:
                begin
                    if (sts.piv_zero)
                    begin
                        r_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else if (more(i_reg, n_eff))
                    begin
                        r_next     = i_reg + 1'b1;
                        state_next = ST_FACT;
                    end
                    else
                    begin
                        k_next     = COL_B;
                        state_next = ST_NORM;
                    end
                end
                ST_FACT:
                begin
                    if (more(r_reg, n_eff))
                        r_next = r_reg + 1'b1;
                    else
                    begin
                        r_next     = i_reg + 1'b1;
                        k_next     = next_col(i_reg, n_eff);
                        state_next = ST_ELIM;
                    end
                end
                ST_ELIM:
                begin
                    if (k_reg != COL_B)
                        k_next = next_col(k_reg, n_eff);
                    else
                    begin
                        k_next = next_col(i_reg, n_eff);
                        if (more(r_reg, n_eff))
                            r_next = r_reg + 1'b1;
                        else
                            state_next = ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (k_reg != COL_B)
                        k_next = next_col(k_reg, n_eff);
                    else if (more(i_reg, n_eff))
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_PIV;
                    end
                    else
                        state_next = ST_BINIT;
                end
                ST_BINIT:
                begin
                    if (more(i_reg, n_eff))
                    begin
                        k_next     = n_eff - 1'b1;
                        state_next = ST_BSUB;
                    end
                    else
                        state_next = ST_BSTORE;
                end
                ST_BSUB:
                begin
                    if (k_reg == i_reg + 1'b1)
                        state_next = ST_BSTORE;
                    else
                        k_next = k_reg - 1'b1;
                end
                ST_BSTORE:
                begin
                    if (i_reg == '0)
                    begin
                        r_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = ST_BINIT;
                    end
                end
                ST_EMIT:
                begin
                    if (more(r_reg, n_eff))
                        r_next = r_reg + 1'b1;
                    else
                        state_next = ST_IDLE;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            order_reg <= ORDER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (cfg_write_en)
                order_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        r_reg <= r_next;
        k_reg <= k_next;
        a_reg <= a_next;
    end

    assign idx_i    = i_reg;
    assign idx_r    = r_reg;
    assign idx_k    = k_reg;
    assign cpy_addr = a_reg;

endmodule
